// ----- rtl/sscnt_pkg.sv -----
// sscnt_pkg: shared types and constants for the subset-sum counter.
// No dependencies.
package sscnt_pkg;

    localparam int TARGET_W = 40;
    localparam int COUNT_W  = 33;
    localparam int ITEM_W   = 32;

    typedef struct packed {
        logic [ITEM_W-1:0] item_value;
        logic              is_last;
    } t_in;

    typedef struct packed {
        logic [COUNT_W-1:0] subset_count;
        logic               overflow;
    } t_out;

    typedef enum logic [4:0] {
        S_LOAD,
        S_SETUP,
        S_INIT,
        S_PASS,
        S_VAL,
        S_MRD,
        S_MWR,
        S_CRD,
        S_CCMP,
        S_LRD,
        S_LCMP,
        S_RRD,
        S_RCMP,
        S_MUL,
        S_ACC,
        S_DONE
    } t_state;

endpackage

// ----- rtl/sscnt_list_mem.sv -----
// sscnt_list_mem: sum-list RAM, one write port and two registered read ports.
// No dependencies.
module sscnt_list_mem #(
    parameter int AW = 18,
    parameter int DW = 37
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr0,
    input  logic [AW-1:0] i_raddr1,
    output logic [DW-1:0] o_rdata0,
    output logic [DW-1:0] o_rdata1
);
    logic [DW-1:0] r_mem [0:(1<<AW)-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end
endmodule

// ----- rtl/subset_sum_count.sv -----
// subset_sum_count: top level of the meet-in-the-middle subset-sum counter.
// Depends on sscnt_pkg and sscnt_list_mem.
//
// Values are loaded one transaction per cycle, while the state is LOAD, into a
// value RAM. The transaction with is_last set closes the set: the first half of
// the values and the second half each get a sorted list of all their subset
// sums, built in a list RAM by one merge pass per value (each merged entry is
// read in MRD and written in MWR). A two-pointer sweep over the two lists, each
// step a read in CRD and a compare in CCMP, plus a multiply/accumulate per run
// of equal sums, then yields the count of subsets (empty one included) whose
// total equals target_sum. All of it is bound by the list RAM's ports. One result
// transaction follows; loading of the next set may start while it waits.
// Values past MAX_ITEMS are dropped and flagged in the result's overflow bit.
module subset_sum_count #(
    parameter int MAX_ITEMS  = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  sscnt_pkg::t_in                i_in,
    output logic                          o_valid,
    input  logic                          i_ready,
    output sscnt_pkg::t_out               o_out,
    input  logic                          i_cfg_we,
    input  logic [sscnt_pkg::TARGET_W-1:0] i_cfg_data
);
    import sscnt_pkg::*;

    localparam int HALF_MAX = MAX_ITEMS - MAX_ITEMS / 2;
    localparam int IDX_W    = HALF_MAX;
    localparam int AW       = IDX_W + 2;
    localparam int CNT_W    = $clog2(MAX_ITEMS + 1);
    localparam int VA_W     = $clog2(MAX_ITEMS);
    localparam int SUM_W    = VALUE_BITS + $clog2(HALF_MAX + 1);
    localparam int CW       = (SUM_W + 1 > TARGET_W) ? SUM_W + 1 : TARGET_W;
    localparam int PRD_W    = 2 * (IDX_W + 1);
    localparam int ACC_W    = (PRD_W + 1 > COUNT_W + 1) ? PRD_W + 1 : COUNT_W + 1;
    localparam logic [ACC_W-1:0] COUNT_MAX = ACC_W'({COUNT_W{1'b1}});

    t_state r_state, n_state;

    logic [TARGET_W-1:0]   r_target;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_ovf;
    logic                  r_half;      // 0: first half, 1: second half
    logic                  r_pp;        // ping/pong region within the half
    logic                  r_lpp, r_rpp;
    logic [CNT_W-1:0]      r_base, r_k, r_t;
    logic [VALUE_BITS-1:0] r_v;
    logic [IDX_W:0]        r_m, r_a, r_b, r_o;
    logic [IDX_W:0]        r_lsize;
    logic [IDX_W:0]        r_i, r_j, r_ca, r_cb;
    logic [SUM_W-1:0]      r_lv, r_rv;
    logic [PRD_W-1:0]      r_prod;
    logic [COUNT_W-1:0]    r_total;
    logic                  r_out_valid;
    t_out                  r_out;

    // value RAM
    logic [VALUE_BITS-1:0] r_vmem [0:MAX_ITEMS-1];
    logic [VALUE_BITS-1:0] r_vq;
    logic [VA_W-1:0]       w_vraddr;

    // list RAM
    logic             w_we;
    logic [AW-1:0]    w_waddr, w_raddr0, w_raddr1;
    logic [SUM_W-1:0] w_wdata, w_q0, w_q1;

    sscnt_list_mem #(.AW(AW), .DW(SUM_W)) u_mem (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_waddr  (w_waddr),
        .i_wdata  (w_wdata),
        .i_raddr0 (w_raddr0),
        .i_raddr1 (w_raddr1),
        .o_rdata0 (w_q0),
        .o_rdata1 (w_q1)
    );

    logic             w_in_acc;
    logic [SUM_W-1:0] w_y;
    logic             w_take_a;
    logic [CW-1:0]    w_s, w_tgt;
    logic [ACC_W-1:0] w_acc;
    logic [CNT_W-1:0] w_nl;
    logic             w_emit;

    assign o_ready  = (r_state == S_LOAD);
    assign w_in_acc = i_valid && o_ready;
    assign o_valid  = r_out_valid;
    assign o_out    = r_out;

    assign w_y      = w_q1 + SUM_W'(r_v);
    assign w_take_a = (r_b >= r_m) || ((r_a < r_m) && (w_q0 <= w_y));
    assign w_s      = CW'(w_q0) + CW'(w_q1);
    assign w_tgt    = CW'(r_target);
    assign w_acc    = ACC_W'(r_total) + ACC_W'(r_prod);
    assign w_nl     = r_cnt >> 1;
    assign w_vraddr = VA_W'(r_base + r_t);
    // result register is free (or being freed) while the count waits in DONE
    assign w_emit   = (r_state == S_DONE) && (!r_out_valid || i_ready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD:  if (w_in_acc && i_in.is_last) n_state = S_SETUP;
            S_SETUP: n_state = S_INIT;
            S_INIT:  n_state = S_PASS;
            S_PASS: begin
                if (r_t != r_k)      n_state = S_VAL;
                else if (!r_half)    n_state = S_SETUP;
                else                 n_state = S_CRD;
            end
            S_VAL:   n_state = S_MRD;
            S_MRD:   n_state = (r_a == r_m && r_b == r_m) ? S_PASS : S_MWR;
            S_MWR:   n_state = S_MRD;
            S_CRD:   n_state = (r_i == r_lsize || r_j == '0) ? S_DONE : S_CCMP;
            S_CCMP:  n_state = (w_s == w_tgt) ? S_LRD : S_CRD;
            S_LRD:   n_state = (r_i == r_lsize) ? S_RRD : S_LCMP;
            S_LCMP:  n_state = (w_q0 == r_lv) ? S_LRD : S_RRD;
            S_RRD:   n_state = (r_j == '0) ? S_MUL : S_RCMP;
            S_RCMP:  n_state = (w_q1 == r_rv) ? S_RRD : S_MUL;
            S_MUL:   n_state = S_ACC;
            S_ACC:   n_state = S_CRD;
            S_DONE:  if (!r_out_valid || i_ready) n_state = S_LOAD;
            default: n_state = S_LOAD;
        endcase
    end

    // list RAM controls
    always_comb begin
        w_we     = 1'b0;
        w_waddr  = {r_half, r_pp, r_o[IDX_W-1:0]};
        w_wdata  = w_take_a ? w_q0 : w_y;
        w_raddr0 = {r_half, r_pp, r_a[IDX_W-1:0]};
        w_raddr1 = {r_half, r_pp, r_b[IDX_W-1:0]};
        case (r_state)
            S_INIT: begin
                w_we    = 1'b1;
                w_waddr = {r_half, r_pp, {IDX_W{1'b0}}};
                w_wdata = '0;
            end
            S_MWR: begin
                w_we    = 1'b1;
                w_waddr = {r_half, ~r_pp, r_o[IDX_W-1:0]};
            end
            S_CRD, S_LRD, S_RRD: begin
                w_raddr0 = {1'b0, r_lpp, r_i[IDX_W-1:0]};
                w_raddr1 = {1'b1, r_rpp, IDX_W'(r_j - 1'b1)};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && r_cnt < CNT_W'(MAX_ITEMS)) begin
            r_vmem[VA_W'(r_cnt)] <= VALUE_BITS'(i_in.item_value);
        end
        r_vq <= r_vmem[w_vraddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_target    <= '0;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_half      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_target <= i_cfg_data;
            if (w_emit)                      r_out_valid <= 1'b1;
            else if (r_out_valid && i_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        if (r_cnt < CNT_W'(MAX_ITEMS)) r_cnt <= r_cnt + 1'b1;
                        else                           r_ovf <= 1'b1;
                        if (i_in.is_last) begin
                            r_half <= 1'b1; // toggled to first half in SETUP
                        end
                    end
                end
                S_SETUP: begin
                    // first half: values [0, nl); second half: [nl, cnt)
                    r_half <= ~r_half;
                    r_pp   <= 1'b0;
                    r_t    <= '0;
                    r_m    <= (IDX_W+1)'(1);
                    if (r_half) begin
                        r_base <= '0;
                        r_k    <= w_nl;
                    end else begin
                        r_base <= w_nl;
                        r_k    <= r_cnt - w_nl;
                    end
                end
                S_PASS: begin
                    if (r_t == r_k) begin
                        if (!r_half) begin
                            r_lpp   <= r_pp;
                            r_lsize <= r_m;
                        end else begin
                            r_rpp   <= r_pp;
                            r_i     <= '0;
                            r_j     <= r_m;
                            r_total <= '0;
                        end
                    end
                end
                S_VAL: begin
                    r_v <= r_vq;
                    r_a <= '0;
                    r_b <= '0;
                    r_o <= '0;
                end
                S_MRD: begin
                    if (r_a == r_m && r_b == r_m) begin
                        r_m  <= r_m << 1;
                        r_pp <= ~r_pp;
                        r_t  <= r_t + 1'b1;
                    end
                end
                S_MWR: begin
                    r_o <= r_o + 1'b1;
                    if (w_take_a) r_a <= r_a + 1'b1;
                    else          r_b <= r_b + 1'b1;
                end
                S_CCMP: begin
                    if (w_s < w_tgt)      r_i <= r_i + 1'b1;
                    else if (w_s > w_tgt) r_j <= r_j - 1'b1;
                    else begin
                        r_lv <= w_q0;
                        r_rv <= w_q1;
                        r_ca <= '0;
                        r_cb <= '0;
                    end
                end
                S_LCMP: begin
                    if (w_q0 == r_lv) begin
                        r_i  <= r_i + 1'b1;
                        r_ca <= r_ca + 1'b1;
                    end
                end
                S_RCMP: begin
                    if (w_q1 == r_rv) begin
                        r_j  <= r_j - 1'b1;
                        r_cb <= r_cb + 1'b1;
                    end
                end
                S_MUL: r_prod <= r_ca * r_cb;
                S_ACC: begin
                    // saturate at the top of the count field
                    r_total <= (w_acc > COUNT_MAX) ? COUNT_W'(COUNT_MAX)
                                                   : COUNT_W'(w_acc);
                end
                S_DONE: begin
                    if (w_emit) begin
                        r_out.subset_count <= r_total;
                        r_out.overflow     <= r_ovf;
                        r_cnt              <= '0;
                        r_ovf              <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// ----- tb/sv/subset_sum_count_tb.sv -----
// subset_sum_count_tb: self-checking testbench for the subset-sum counter.
// Depends on sscnt_pkg and subset_sum_count; drives random and directed sets.
module subset_sum_count_tb;
    import sscnt_pkg::*;

    localparam int  SET_MAX    = 32;        // MAX_ITEMS of the block
    localparam int  STALL_LIMIT = 4000000;
    localparam int  SETTLE     = 50;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    t_in                 i_in;
    logic                o_valid;
    logic                i_ready;
    t_out                o_out;
    logic                i_cfg_we;
    logic [TARGET_W-1:0] i_cfg_data;

    subset_sum_count #(.MAX_ITEMS(SET_MAX), .VALUE_BITS(32)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // shadow of the block: target register, values held, overflow flag
    logic [TARGET_W-1:0] target_sum;
    logic [ITEM_W-1:0]   held_values[$];
    logic                held_ovf;
    t_out                count_q[$];      // expected results, oldest first

    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold;                          // receiver hold-off, counted down
    int errors;
    int quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Meet in the middle: tally left-half sums, then look up target - right sum.
    function automatic logic [COUNT_W-1:0] count_subsets(logic [ITEM_W-1:0] vals[$],
                                                         logic [TARGET_W-1:0] goal);
        longint unsigned left_sums[$];
        longint unsigned right_sums[$];
        int unsigned     tally[longint unsigned];
        longint unsigned total;
        int              nl;
        int              m;
        nl = vals.size() / 2;
        left_sums.insert(0, 0);
        right_sums.insert(0, 0);
        for (int t = 0; t < vals.size(); t++) begin
            if (t < nl) begin
                m = left_sums.size();
                for (int i = 0; i < m; i++)
                    left_sums.insert(left_sums.size(), left_sums[i] + vals[t]);
            end else begin
                m = right_sums.size();
                for (int i = 0; i < m; i++)
                    right_sums.insert(right_sums.size(), right_sums[i] + vals[t]);
            end
        end
        foreach (left_sums[i]) begin
            if (tally.exists(left_sums[i])) tally[left_sums[i]]++;
            else tally[left_sums[i]] = 1;
        end
        total = 0;
        foreach (right_sums[i]) begin
            if (right_sums[i] <= goal && tally.exists(goal - right_sums[i]))
                total += tally[goal - right_sums[i]];
        end
        // saturate at the top of the count field
        if ((total >> COUNT_W) != 0) total = (64'd1 << COUNT_W) - 64'd1;
        return total[COUNT_W-1:0];
    endfunction

    // Shadow update for one accepted input transaction.
    function automatic void absorb_value(t_in tr);
        t_out res;
        if (held_values.size() < SET_MAX)
            held_values.insert(held_values.size(), tr.item_value);
        else held_ovf = 1'b1;
        if (tr.is_last) begin
            res.subset_count = count_subsets(held_values, target_sum);
            res.overflow     = held_ovf;
            count_q.insert(count_q.size(), res);
            held_values.delete();
            held_ovf = 1'b0;
        end
    endfunction

    // Offer one value; returns after the transaction is accepted.
    // Valid stays high afterwards so back-to-back values need no gap.
    task automatic send_value(logic [ITEM_W-1:0] value, logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in.item_value = value;
        i_in.is_last    = last;
        i_valid         = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        absorb_value(i_in);
    endtask

    task automatic send_set(logic [ITEM_W-1:0] vals[$]);
        foreach (vals[i]) send_value(vals[i], i == vals.size() - 1);
    endtask

    // Drop valid and wait for every pending count, then let the block settle.
    task automatic drain_counts();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (count_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_target(logic [TARGET_W-1:0] goal);
        drain_counts();
        i_cfg_we   = 1'b1;
        i_cfg_data = goal;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        target_sum = goal;
    endtask

    // Receiver: random ready, or held low while a hold-off is counting down.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready = 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            i_ready = 1'b0;
        end else begin
            i_ready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Result checker: each result transaction against the oldest expectation.
    always @(posedge i_clk) begin
        t_out exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            if (count_q.size() == 0) begin
                $display("%0t: unexpected result count=%0d ovf=%0b", $time,
                         o_out.subset_count, o_out.overflow);
                errors++;
            end else begin
                exp_res = count_q.pop_front();
                if (o_out.subset_count !== exp_res.subset_count) begin
                    $display("%0t: subset_count expected %0d actual %0d", $time,
                             exp_res.subset_count, o_out.subset_count);
                    errors++;
                end
                if (o_out.overflow !== exp_res.overflow) begin
                    $display("%0t: overflow expected %0b actual %0b", $time,
                             exp_res.overflow, o_out.overflow);
                    errors++;
                end
            end
        end
    end

    // Watchdog: any transaction on either channel restarts the count.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Edge values, empty subset, target extremes.
    task automatic test_directed();
        logic [ITEM_W-1:0] s[$];
        s = '{32'd0};                  send_set(s);   // target 0: {} and {0}
        s = '{32'hFFFF_FFFF};          send_set(s);
        write_target(40'hFF_FFFF_FFFF);
        s = '{32'hFFFF_FFFF, 32'd1};   send_set(s);
        write_target(40'd5);
        s = '{32'd1, 32'd2, 32'd3, 32'd4}; send_set(s);
        s = '{32'd5, 32'd5, 32'd0};    send_set(s);
        write_target(40'h1_FFFF_FFFE);
        s = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hAAAA_5555}; send_set(s);
        drain_counts();
    endtask

    // Too many values: 34 zeros, target 0 -> 2^32 matches and overflow set.
    task automatic test_overflow_full();
        logic [ITEM_W-1:0] s[$];
        write_target(40'd0);
        repeat (34) s.insert(s.size(), 32'd0);
        send_set(s);
        drain_counts();
    endtask

    // Random sets: mostly small sizes, narrow values so matches are common.
    task automatic test_random_sets(int n_items);
        logic [ITEM_W-1:0] s[$];
        longint unsigned   pick;
        int                sent;
        int                len;
        int                wide;
        sent = 0;
        while (sent < n_items) begin
            s.delete();
            len  = ($urandom_range(19) == 0) ? $urandom_range(11, 22) : $urandom_range(1, 9);
            wide = $urandom_range(3);
            for (int i = 0; i < len; i++)
                s.insert(s.size(), wide == 0 ? $urandom() : $urandom_range(0, 20));
            if ($urandom_range(3) == 0) begin
                pick = 0;
                foreach (s[i]) if ($urandom_range(1)) pick += s[i];
                if ($urandom_range(7) == 0) pick = {$urandom(), $urandom()} & 40'hFF_FFFF_FFFF;
                write_target(pick[TARGET_W-1:0]);
            end
            send_set(s);
            sent += len;
        end
        drain_counts();
    endtask

    // Receiver holds off while several sets are offered, so the block backs up.
    task automatic test_backpressure();
        logic [ITEM_W-1:0] s[$];
        write_target(40'd10);
        rx_hold = 3000;
        repeat (6) begin
            s.delete();
            repeat ($urandom_range(2, 6)) s.insert(s.size(), $urandom_range(0, 8));
            send_set(s);
        end
        drain_counts();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_in        = '0;
        i_ready     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        target_sum  = '0;
        held_ovf    = 1'b0;
        errors      = 0;
        quiet_cycles = 0;
        rx_hold     = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_overflow_full();
        tx_idle_pct = 10; rx_idle_pct = 84;
        test_random_sets(400);
        tx_idle_pct = 84; rx_idle_pct = 10;
        test_random_sets(400);
        tx_idle_pct = 0;  rx_idle_pct = 0;
        test_backpressure();
        test_random_sets(400);

        drain_counts();
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/sscnt_pkg.sv
rtl/sscnt_list_mem.sv
rtl/subset_sum_count.sv
tb/sv/subset_sum_count_tb.sv
